// ===== hw/rtl/assert_macros.svh =====
// Assertion helper macros for the RTL of the range detector.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check at every rising clock edge, off while reset is asserted.
`define ASSERT_RST(name, prop, clk, rst_n, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Check at every rising clock edge, reset included.
`define ASSERT_ALWAYS(name, prop, clk, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(name, prop, clk, rst_n, msg)
`define ASSERT_ALWAYS(name, prop, clk, msg)
`endif

`endif

// ===== hw/rtl/swrd_pkg.sv =====
// Shared types and constants of the sliding window range detector.
// No dependencies; used by swrd_cell and the top level.
`default_nettype none

package swrd_pkg;

  localparam int unsigned SAMPLE_BITS = 20;
  localparam int unsigned COUNT_W     = 21;
  localparam int unsigned WL_W        = 7;
  localparam int unsigned TH_W        = 20;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 20;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 2'd1;

  typedef enum logic {
    KIND_QUIET = 1'b0,
    KIND_NONE  = 1'b1
  } swrd_kind_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_value;
    logic                   last_sample;
  } swrd_in_t;

  typedef struct packed {
    swrd_kind_e         kind;
    logic [COUNT_W-1:0] window_start;
  } swrd_out_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic                   step;
    logic [SAMPLE_BITS-1:0] feed;
  } swrd_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sliding_window_range_detector.sv =====
// Top level of the sliding window range detector: cell chain, stream
// counter, evaluation stage and output register. Depends on swrd_pkg,
// swrd_cell and assert_macros.svh.
//
//   channel | direction | handshake            | payload
//   in      | sink      | in_valid_i/in_stall_o | swrd_in_t
//   out     | source    | out_valid_o/out_stall_i | swrd_out_t
//   cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One request per cycle while input is not stalled: the cell chain updates
// every window extreme in the accept cycle, the next cycle compares range
// against threshold and loads the output register unless output stalls.
// A window_length write rotates the sample chain once around, rebuilding
// the extremes; input and config wait meanwhile.
// A pending config write stalls input until the evaluation stage is empty
// and the write lands.
// Reset clears counters and flags; sample storage is not cleared.
// A stalled output holds the evaluation stage, which then stalls input.
`default_nettype none
`include "assert_macros.svh"

module sliding_window_range_detector #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire swrd_pkg::swrd_in_t             in_data_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output swrd_pkg::swrd_out_t                 out_data_o,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [swrd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [swrd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned SB    = swrd_pkg::SAMPLE_BITS;
  localparam int unsigned CW    = swrd_pkg::COUNT_W;
  localparam int unsigned IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CMP_W = (IDX_W + 1 > swrd_pkg::WL_W) ? IDX_W + 1 : swrd_pkg::WL_W;
  localparam int unsigned RB_W  = $clog2(MAX_WINDOW + 1);

  // configuration
  logic [IDX_W-1:0]             len_m1_q, len_m1_d;
  logic [swrd_pkg::TH_W-1:0]    th_q, th_d;
  logic [RB_W-1:0]              rb_cnt_q, rb_cnt_d;
  logic                         rb_busy, cfg_fire;
  logic [swrd_pkg::WL_W-1:0]    wl_new;
  logic [CMP_W-1:0]             wl_ext;

  // stream and evaluation stage
  logic [CW-1:0]                stream_cnt_q, stream_cnt_d, cnt_inc;
  logic                         found_q, found_d;
  logic                         ev_valid_q, ev_valid_d;
  logic [CW-1:0]                ev_cnt_q;
  logic                         ev_last_q;
  logic                         ev_go, ev_fire, in_fire;
  logic                         in_win, qualify, produce;
  logic [SB-1:0]                range;
  logic [CW-1:0]                start;

  // output register
  logic                         out_valid_q, out_valid_d;
  swrd_pkg::swrd_out_t          out_q, out_d;

  // cell chain
  swrd_pkg::swrd_ctl_t          ctl;
  logic [SB-1:0]                smp [MAX_WINDOW];
  logic [SB-1:0]                mn  [MAX_WINDOW];
  logic [SB-1:0]                mx  [MAX_WINDOW];

  assign rb_busy     = (rb_cnt_q != '0);
  assign cfg_ready_o = !rb_busy && !ev_valid_q;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  assign ev_go      = !out_valid_q || !out_stall_i;
  assign in_stall_o = rb_busy || cfg_valid_i || (ev_valid_q && !ev_go);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign ev_fire    = ev_valid_q && ev_go;

  assign wl_new = cfg_data_i[swrd_pkg::WL_W-1:0];
  assign wl_ext = CMP_W'(wl_new);

  always_comb begin
    len_m1_d = len_m1_q;
    th_d     = th_q;
    rb_cnt_d = rb_busy ? rb_cnt_q - RB_W'(1) : rb_cnt_q;
    if (cfg_fire) begin
      case (cfg_index_i)
        swrd_pkg::CFG_WINDOW_LENGTH: begin
          // zero acts as one, anything above MAX_WINDOW as MAX_WINDOW
          if (wl_new == '0) begin
            len_m1_d = '0;
          end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
            len_m1_d = IDX_W'(MAX_WINDOW - 1);
          end else begin
            len_m1_d = IDX_W'(wl_ext - CMP_W'(1));
          end
          rb_cnt_d = RB_W'(MAX_WINDOW);
        end
        swrd_pkg::CFG_THRESHOLD: begin
          th_d = cfg_data_i[swrd_pkg::TH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // rebuild replays the stored samples oldest first through the chain
  assign ctl.step = in_fire || rb_busy;
  assign ctl.feed = rb_busy ? smp[MAX_WINDOW-1] : in_data_i.sample_value;

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    logic [SB-1:0] prev_s, next_mn, next_mx;
    if (g == 0) begin : g_head
      assign prev_s = ctl.feed;
    end else begin : g_body
      assign prev_s = smp[g-1];
    end
    if (g == MAX_WINDOW - 1) begin : g_end
      assign next_mn = ctl.feed;
      assign next_mx = ctl.feed;
    end else begin : g_link
      assign next_mn = mn[g+1];
      assign next_mx = mx[g+1];
    end
    swrd_cell #(
      .IdxW  (IDX_W),
      .Index (g)
    ) u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .len_m1_i      (len_m1_q),
      .prev_sample_i (prev_s),
      .next_min_i    (next_mn),
      .next_max_i    (next_mx),
      .sample_o      (smp[g]),
      .min_o         (mn[g]),
      .max_o         (mx[g])
    );
  end

  assign cnt_inc = (stream_cnt_q == swrd_pkg::COUNT_MAX) ? stream_cnt_q : stream_cnt_q + CW'(1);

  always_comb begin
    stream_cnt_d = stream_cnt_q;
    ev_valid_d   = ev_valid_q;
    if (ev_fire) begin
      ev_valid_d = 1'b0;
    end
    if (in_fire) begin
      stream_cnt_d = in_data_i.last_sample ? '0 : cnt_inc;
      ev_valid_d   = 1'b1;
    end
  end

  // cell 0 now covers the newest len samples
  assign in_win  = (ev_cnt_q > CW'(len_m1_q));
  assign range   = mx[0] - mn[0];
  assign qualify = in_win && (range <= th_q);
  assign produce = qualify || (ev_last_q && !found_q);
  assign start   = (ev_cnt_q == swrd_pkg::COUNT_MAX) ? swrd_pkg::COUNT_MAX
                                                     : ev_cnt_q - CW'(len_m1_q);

  always_comb begin
    found_d     = found_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (ev_fire) begin
      found_d     = ev_last_q ? 1'b0 : (found_q || qualify);
      out_valid_d = produce;
      if (qualify) begin
        out_d.kind         = swrd_pkg::KIND_QUIET;
        out_d.window_start = start;
      end else begin
        out_d.kind         = swrd_pkg::KIND_NONE;
        out_d.window_start = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_m1_q     <= '0;
      th_q         <= '0;
      rb_cnt_q     <= '0;
      stream_cnt_q <= '0;
      found_q      <= 1'b0;
      ev_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      len_m1_q     <= len_m1_d;
      th_q         <= th_d;
      rb_cnt_q     <= rb_cnt_d;
      stream_cnt_q <= stream_cnt_d;
      found_q      <= found_d;
      ev_valid_q   <= ev_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ev_cnt_q  <= cnt_inc;
      ev_last_q <= in_data_i.last_sample;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_RST(a_none_has_zero_start,
    (out_valid_q && out_q.kind == swrd_pkg::KIND_NONE) |-> (out_q.window_start == '0),
    clk_i, rst_ni, "none marker with nonzero start")
  `ASSERT_RST(a_quiet_start_nonzero,
    (out_valid_q && out_q.kind == swrd_pkg::KIND_QUIET) |-> (out_q.window_start != '0),
    clk_i, rst_ni, "quiet window with zero start index")
  `ASSERT_RST(a_last_clears_count, (in_fire && in_data_i.last_sample) |=> (stream_cnt_q == '0),
    clk_i, rst_ni, "stream count not cleared after last sample")
  `ASSERT_RST(a_rebuild_when_empty, $rose(rb_busy) |-> !ev_valid_q,
    clk_i, rst_ni, "chain rebuild started with an item in flight")
  `ASSERT_RST(a_held_eval_kept, (ev_valid_q && !ev_go) |=> ev_valid_q,
    clk_i, rst_ni, "stalled evaluation item lost")

endmodule

`default_nettype wire

// ===== hw/rtl/swrd_cell.sv =====
// One cell of the window chain: a stored sample plus the min/max of the
// newest (len - index) samples. Depends on swrd_pkg.
`default_nettype none

module swrd_cell #(
  parameter int unsigned IdxW  = 6,
  parameter int unsigned Index = 0
) (
  input  wire                                clk_i,
  input  wire swrd_pkg::swrd_ctl_t           ctl_i,
  input  wire logic [IdxW-1:0]               len_m1_i,
  input  wire logic [swrd_pkg::SAMPLE_BITS-1:0] prev_sample_i,
  input  wire logic [swrd_pkg::SAMPLE_BITS-1:0] next_min_i,
  input  wire logic [swrd_pkg::SAMPLE_BITS-1:0] next_max_i,
  output logic [swrd_pkg::SAMPLE_BITS-1:0]   sample_o,
  output logic [swrd_pkg::SAMPLE_BITS-1:0]   min_o,
  output logic [swrd_pkg::SAMPLE_BITS-1:0]   max_o
);

  logic [swrd_pkg::SAMPLE_BITS-1:0] sample_q, min_q, max_q;
  logic [swrd_pkg::SAMPLE_BITS-1:0] min_d, max_d;
  logic                             tail;

  // cells at or past len-1 cover just the newest sample
  assign tail = (IdxW'(Index) >= len_m1_i);

  always_comb begin
    if (tail) begin
      min_d = ctl_i.feed;
      max_d = ctl_i.feed;
    end else begin
      min_d = (ctl_i.feed < next_min_i) ? ctl_i.feed : next_min_i;
      max_d = (ctl_i.feed > next_max_i) ? ctl_i.feed : next_max_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.step) begin
      sample_q <= prev_sample_i;
      min_q    <= min_d;
      max_q    <= max_d;
    end
  end

  assign sample_o = sample_q;
  assign min_o    = min_q;
  assign max_o    = max_q;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for sliding_window_range_detector: drives sample requests and
// register writes, predicts quiet-window and none results, and checks every output request.
// Depends on swrd_pkg and the detector RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WINDOW_DEPTH = 64;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned STUCK_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam logic [swrd_pkg::SAMPLE_BITS-1:0] SAMPLE_TOP = {swrd_pkg::SAMPLE_BITS{1'b1}};

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  swrd_pkg::swrd_in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  swrd_pkg::swrd_out_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [swrd_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [swrd_pkg::CFG_DATA_W-1:0] cfg_data_i;

  // shadow of the block: registers and per-stream state
  logic [swrd_pkg::WL_W-1:0] win_len;
  logic [swrd_pkg::TH_W-1:0] range_limit;
  logic [swrd_pkg::SAMPLE_BITS-1:0] sample_ring [WINDOW_DEPTH];
  logic [5:0] ring_head;
  int unsigned stream_count;
  bit quiet_in_stream;

  swrd_pkg::swrd_out_t expected_windows[$];

  bit tx_gaps;
  bit rx_stalls = 1'b0;
  int unsigned hold_req = 0;
  int unsigned stuck_cycles = 0;
  int unsigned error_count = 0;
  int unsigned samples_sent = 0;
  int unsigned streams_done = 0;
  int unsigned reg_writes = 0;
  int unsigned quiet_seen = 0;
  int unsigned none_seen = 0;

  sliding_window_range_detector i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned eff_window();
    if (win_len == '0) return 1;
    if (win_len > WINDOW_DEPTH) return WINDOW_DEPTH;
    return win_len;
  endfunction

  // Advances the shadow stream by one accepted sample and queues what it causes.
  function automatic void track_sample(input logic [swrd_pkg::SAMPLE_BITS-1:0] v,
                                       input logic last);
    int unsigned len;
    logic [swrd_pkg::SAMPLE_BITS-1:0] lo, hi, x;
    logic [swrd_pkg::COUNT_W-1:0] start;
    len = eff_window();
    ring_head = ring_head + 6'd1;
    sample_ring[ring_head] = v;
    if (stream_count < swrd_pkg::COUNT_MAX) stream_count++;
    if (stream_count >= len) begin
      lo = v;
      hi = v;
      for (int unsigned i = 1; i < len; i++) begin
        x = sample_ring[ring_head - 6'(i)];
        if (x < lo) lo = x;
        if (x > hi) hi = x;
      end
      if (hi - lo <= range_limit) begin
        start = (stream_count >= swrd_pkg::COUNT_MAX) ? swrd_pkg::COUNT_MAX
                                                      : swrd_pkg::COUNT_W'(stream_count - len + 1);
        quiet_in_stream = 1'b1;
        expected_windows.push_back('{kind: swrd_pkg::KIND_QUIET, window_start: start});
      end
    end
    if (last) begin
      if (!quiet_in_stream)
        expected_windows.push_back('{kind: swrd_pkg::KIND_NONE, window_start: '0});
      stream_count = 0;
      quiet_in_stream = 1'b0;
      streams_done++;
    end
  endfunction

  // one sample request per call; valid stays up if the next call has no gap
  task automatic send_sample(input logic [swrd_pkg::SAMPLE_BITS-1:0] v, input logic last);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{sample_value: v, last_sample: last};
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    samples_sent++;
    track_sample(v, last);
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (expected_windows.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [swrd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [swrd_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    case (idx)
      swrd_pkg::CFG_WINDOW_LENGTH: win_len = data[swrd_pkg::WL_W-1:0];
      swrd_pkg::CFG_THRESHOLD:     range_limit = data[swrd_pkg::TH_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk_i);
  endtask

  task automatic test_reset_values();
    send_sample('0, 1'b0);
    send_sample(SAMPLE_TOP, 1'b1);
  endtask

  task automatic test_directed_cases();
    wait_quiet();
    // upper data bits are ignored: length field reads as zero, i.e. one
    write_reg(swrd_pkg::CFG_WINDOW_LENGTH, 20'hFFF80);
    send_sample(20'h12345, 1'b1);
    // stream shorter than the window
    wait_quiet();
    write_reg(swrd_pkg::CFG_WINDOW_LENGTH, 20'd3);
    send_sample(20'd5, 1'b0);
    send_sample(20'd5, 1'b1);
    // quiet window closed by the final sample
    wait_quiet();
    write_reg(swrd_pkg::CFG_THRESHOLD, 20'd16);
    send_sample(20'd100, 1'b0);
    send_sample(20'd110, 1'b0);
    send_sample(20'd105, 1'b0);
    send_sample(SAMPLE_TOP, 1'b0);
    send_sample(SAMPLE_TOP, 1'b0);
    send_sample(SAMPLE_TOP, 1'b1);
    // range exactly at the threshold, then one above
    wait_quiet();
    write_reg(swrd_pkg::CFG_WINDOW_LENGTH, 20'd2);
    write_reg(swrd_pkg::CFG_THRESHOLD, 20'd5);
    send_sample(20'd10, 1'b0);
    send_sample(20'd15, 1'b0);
    send_sample(20'd21, 1'b0);
    send_sample(20'd0, 1'b1);
    // length grows in the middle of a stream
    wait_quiet();
    write_reg(swrd_pkg::CFG_THRESHOLD, 20'd0);
    send_sample(20'd7, 1'b0);
    send_sample(20'd7, 1'b0);
    wait_quiet();
    write_reg(swrd_pkg::CFG_WINDOW_LENGTH, 20'd4);
    send_sample(20'd7, 1'b0);
    send_sample(20'd7, 1'b1);
    // full windows, none quiet
    wait_quiet();
    write_reg(swrd_pkg::CFG_WINDOW_LENGTH, 20'd2);
    send_sample('0, 1'b0);
    send_sample(SAMPLE_TOP, 1'b1);
  endtask

  task automatic test_window_clamp();
    wait_quiet();
    write_reg(swrd_pkg::CFG_WINDOW_LENGTH, 20'd127);
    write_reg(swrd_pkg::CFG_THRESHOLD, 20'd0);
    repeat (66) send_sample(20'h0ABCD, 1'b0);
    send_sample('0, 1'b1);
    // widest legal window at the widest range
    wait_quiet();
    write_reg(swrd_pkg::CFG_WINDOW_LENGTH, 20'd64);
    write_reg(swrd_pkg::CFG_THRESHOLD, 20'hFFFFF);
    for (int i = 0; i < 64; i++) send_sample(i[0] ? SAMPLE_TOP : '0, i == 63);
  endtask

  task automatic test_backpressure();
    wait_quiet();
    write_reg(swrd_pkg::CFG_WINDOW_LENGTH, 20'd1);
    write_reg(swrd_pkg::CFG_THRESHOLD, 20'($urandom));
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    hold_req  = HOLD_CYCLES;
    for (int i = 0; i < 80; i++) send_sample(20'($urandom), i == 79);
  endtask

  task automatic test_random_streams(input int unsigned n_items);
    int unsigned sent, phase_left, stream_left, spread, base, eff;
    logic [swrd_pkg::WL_W-1:0] len_sel;
    logic [swrd_pkg::TH_W-1:0] thr_sel;
    logic [swrd_pkg::SAMPLE_BITS-1:0] v;
    sent = 0;
    stream_left = 0;
    spread = 0;
    base = 0;
    while (sent < n_items) begin
      wait_quiet();
      case ($urandom_range(0, 9))
        0:       len_sel = 7'd0;
        1:       len_sel = 7'd64;
        2:       len_sel = 7'($urandom_range(65, 127));
        3, 4:    len_sel = 7'($urandom_range(9, 63));
        default: len_sel = 7'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 5))
        0:       thr_sel = '0;
        1:       thr_sel = 20'hFFFFF;
        2:       thr_sel = 20'($urandom);
        default: thr_sel = 20'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 4) != 0)
        write_reg(swrd_pkg::CFG_WINDOW_LENGTH, {13'($urandom), len_sel});
      if ($urandom_range(0, 4) != 0) write_reg(swrd_pkg::CFG_THRESHOLD, thr_sel);
      tx_gaps   = $urandom_range(0, 3) != 0;
      rx_stalls = $urandom_range(0, 3) != 0;
      eff = eff_window();
      phase_left = $urandom_range(eff, 2 * eff + 40);
      // a stream left open here carries over into the next setting
      while (phase_left > 0 && sent < n_items) begin
        if (stream_left == 0) begin
          stream_left = ($urandom_range(0, 5) == 0) ? $urandom_range(1, eff)
                                                      : $urandom_range(eff, 3 * eff + 10);
          case ($urandom_range(0, 3))
            0:       spread = SAMPLE_TOP;
            1:       spread = range_limit + $urandom_range(1, 64);
            default: spread = range_limit;
          endcase
          if (spread > SAMPLE_TOP) spread = SAMPLE_TOP;
          base = $urandom_range(0, SAMPLE_TOP - spread);
        end
        v = swrd_pkg::SAMPLE_BITS'(base + $urandom_range(0, spread));
        if ($urandom_range(0, 40) == 0) v = swrd_pkg::SAMPLE_BITS'($urandom);
        send_sample(v, stream_left == 1);
        stream_left--;
        phase_left--;
        sent++;
      end
    end
  endtask

  // output side: random stall ahead of each result request, one long hold on demand
  initial begin
    int unsigned n;
    out_stall_i <= 1'b0;
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
      end else begin
        n = rx_stalls ? $urandom_range(0, 4) : 0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && out_stall_i == 1'b0));
    end
  end

  always @(posedge clk_i) begin
    swrd_pkg::swrd_out_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (out_data_o.kind == swrd_pkg::KIND_QUIET) quiet_seen++;
      else none_seen++;
      if (expected_windows.size() == 0) begin
        if (error_count < 10)
          $display("ERROR: unexpected result kind=%0d start=%0d at %0t",
                   out_data_o.kind, out_data_o.window_start, $realtime);
        error_count++;
      end else begin
        want = expected_windows.pop_front();
        if (out_data_o.kind !== want.kind || out_data_o.window_start !== want.window_start) begin
          if (error_count < 10)
            $display("ERROR: expected kind=%0d start=%0d, got kind=%0d start=%0d at %0t",
                     want.kind, want.window_start, out_data_o.kind,
                     out_data_o.window_start, $realtime);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Timeout: no request moved for %0d cycles", STUCK_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    tx_gaps = 1'b1;
    win_len = 7'd1;
    range_limit = '0;
    ring_head = '0;
    stream_count = 0;
    quiet_in_stream = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_directed_cases();
    test_window_clamp();
    test_backpressure();
    test_random_streams(900);
    wait_quiet();

    $display("Covered %0d samples in %0d streams with %0d register writes",
             samples_sent, streams_done, reg_writes);
    $display("Checked %0d quiet-window and %0d none results, %0d errors",
             quiet_seen, none_seen, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
